@@ hw/rtl/heading_turn_pid_controller_macros.svh @@
// assertion macros shared by the heading pid checker
// no dependencies; included by files that carry concurrent assertions
`ifndef HEADING_TURN_PID_CONTROLLER_MACROS_SVH
`define HEADING_TURN_PID_CONTROLLER_MACROS_SVH

// antecedent implies consequent in the same cycle, checked out of reset
`define HTPID_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the following cycle, checked out of reset
`define HTPID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/htpid_pkg.sv @@
// shared types, constants and register codes for the heading pid controller
// no dependencies; imported by every rtl module of the block but the checker
package htpid_pkg;

    // angles are q4.12 radians
    localparam int ANG_PI     = 12868;
    localparam int ANG_TWO_PI = 25736;
    localparam int FRAC_BITS  = 20;

    localparam int POWER_LIMIT = 127;
    localparam int LIMIT_EFF   = (POWER_LIMIT > 127) ? 127 : POWER_LIMIT;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ANGLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_WINDOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_BAND     = 3'd5;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef struct packed {
        logic signed [15:0] target_angle;
        logic [15:0]        gain_p;
        logic [15:0]        gain_i;
        logic [15:0]        gain_d;
        logic [14:0]        integral_window;
        logic [14:0]        settle_band;
    } t_cfg;

    typedef struct packed {
        logic               restart;
        logic               settled;
        logic signed [16:0] err;
        logic signed [31:0] err_sum;
        logic signed [16:0] deriv;
    } t_err_stage;

    typedef struct packed {
        logic               restart;
        logic               settled;
        logic signed [33:0] p_term;
        logic signed [48:0] i_term;
        logic signed [33:0] d_term;
    } t_prod_stage;

endpackage

@@ hw/rtl/htpid_if.sv @@
// valid/ready channel interfaces for command and result transfers
// no dependencies; used by the top level of the heading pid controller
interface htpid_cmd_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic signed [15:0] measured_heading;

    modport source (output valid, output operation, output measured_heading, input ready);
    modport sink   (input valid, input operation, input measured_heading, output ready);
endinterface

interface htpid_res_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] drive_power;
    logic              settled;

    modport source (output valid, output drive_power, output settled, input ready);
    modport sink   (input valid, input drive_power, input settled, output ready);
endinterface

@@ hw/rtl/htpid_cfg.sv @@
// configuration register file with write decode and reset defaults
// depends on htpid_pkg
module htpid_cfg
    import htpid_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TARGET_ANGLE:    n_cfg.target_angle    = $signed(i_cfg_data);
                CFG_GAIN_P:          n_cfg.gain_p          = i_cfg_data;
                CFG_GAIN_I:          n_cfg.gain_i          = i_cfg_data;
                CFG_GAIN_D:          n_cfg.gain_d          = i_cfg_data;
                CFG_INTEGRAL_WINDOW: n_cfg.integral_window = i_cfg_data[14:0];
                CFG_SETTLE_BAND:     n_cfg.settle_band     = i_cfg_data[14:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_angle    <= 16'sd0;
            r_cfg.gain_p          <= 16'd51200;
            r_cfg.gain_i          <= 16'd512;
            r_cfg.gain_d          <= 16'd0;
            r_cfg.integral_window <= 15'd369;
            r_cfg.settle_band     <= 15'd410;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/htpid_error.sv @@
// error stage: angle wrap, windowed saturating integrator, derivative
// depends on htpid_pkg; holds the error sum and previous error state
module htpid_error
    import htpid_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic               i_operation,
    input  logic signed [15:0] i_heading,
    input  t_cfg               i_cfg,
    output t_err_stage         o_stage
);

    localparam logic signed [18:0] PI_W = 19'(ANG_PI);

    logic signed [31:0] r_err_sum;
    logic signed [31:0] n_err_sum;
    logic signed [16:0] r_last_err;
    logic signed [16:0] n_last_err;
    t_err_stage         r_stage;
    t_err_stage         n_stage;

    logic signed [16:0] raw_err;
    logic signed [18:0] raw_ext;
    logic signed [18:0] cand;
    logic signed [18:0] wrapped;
    logic signed [16:0] err;
    logic [16:0]        err_mag;
    logic signed [32:0] sum_ext;
    logic signed [31:0] sum_win;
    logic               sign_flip;

    assign raw_err = {i_cfg.target_angle[15], i_cfg.target_angle} - {i_heading[15], i_heading};
    assign raw_ext = {{2{raw_err[16]}}, raw_err};

    // exactly one shift by a multiple of 2*pi lands in (-pi, pi]
    always_comb begin
        wrapped = raw_ext;
        cand    = raw_ext;
        for (int k = -3; k <= 3; k++) begin
            cand = raw_ext + 19'(k * ANG_TWO_PI);
            if (cand > -PI_W && cand <= PI_W) begin
                wrapped = cand;
            end
        end
    end

    assign err     = wrapped[16:0];
    assign err_mag = err[16] ? 17'(-err) : 17'(err);
    assign sum_ext = {r_err_sum[31], r_err_sum} + {{16{err[16]}}, err};

    always_comb begin
        if (sum_ext[32] != sum_ext[31]) begin
            sum_win = sum_ext[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            sum_win = sum_ext[31:0];
        end
    end

    assign sign_flip = (err < 0 && r_last_err > 0) || (err > 0 && r_last_err < 0);

    always_comb begin
        n_err_sum  = r_err_sum;
        n_last_err = r_last_err;
        n_stage    = r_stage;
        if (i_load) begin
            if (i_operation == OP_RESTART) begin
                n_err_sum       = 32'sd0;
                n_last_err      = 17'sd0;
                n_stage.restart = 1'b1;
                n_stage.settled = 1'b0;
                n_stage.err     = 17'sd0;
                n_stage.err_sum = 32'sd0;
                n_stage.deriv   = 17'sd0;
            end else begin
                if (err_mag < {2'b00, i_cfg.integral_window} && !sign_flip) begin
                    n_err_sum = sum_win;
                end else begin
                    n_err_sum = 32'sd0;
                end
                n_last_err      = err;
                n_stage.restart = 1'b0;
                n_stage.settled = err_mag < {2'b00, i_cfg.settle_band};
                n_stage.err     = err;
                n_stage.err_sum = n_err_sum;
                n_stage.deriv   = err - r_last_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_sum  <= 32'sd0;
            r_last_err <= 17'sd0;
        end else begin
            r_err_sum  <= n_err_sum;
            r_last_err <= n_last_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
    end

    assign o_stage = r_stage;

endmodule

@@ hw/rtl/htpid_mult.sv @@
// multiply stage: p, i and d products against the q8.8 gains
// depends on htpid_pkg
module htpid_mult
    import htpid_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_load,
    input  t_err_stage  i_stage,
    input  t_cfg        i_cfg,
    output t_prod_stage o_stage
);

    t_prod_stage        r_stage;
    logic signed [16:0] gain_p_s;
    logic signed [16:0] gain_i_s;
    logic signed [16:0] gain_d_s;

    assign gain_p_s = $signed({1'b0, i_cfg.gain_p});
    assign gain_i_s = $signed({1'b0, i_cfg.gain_i});
    assign gain_d_s = $signed({1'b0, i_cfg.gain_d});

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_stage.restart <= i_stage.restart;
            r_stage.settled <= i_stage.settled;
            r_stage.p_term  <= i_stage.err * gain_p_s;
            r_stage.i_term  <= i_stage.err_sum * gain_i_s;
            r_stage.d_term  <= i_stage.deriv * gain_d_s;
        end
    end

    assign o_stage = r_stage;

endmodule

@@ hw/rtl/htpid_sum.sv @@
// output stage: add products, floor to integer power, clamp, deadband
// depends on htpid_pkg
module htpid_sum
    import htpid_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_load,
    input  t_prod_stage       i_stage,
    output logic signed [7:0] o_drive_power,
    output logic              o_settled
);

    localparam logic signed [29:0] PWR_MAX = 30'(LIMIT_EFF);
    localparam logic signed [29:0] PWR_MIN = -PWR_MAX;

    logic signed [49:0] acc;
    logic signed [29:0] pwr;
    logic signed [7:0]  n_drive_power;
    logic               n_settled;
    logic signed [7:0]  r_drive_power;
    logic               r_settled;

    assign acc = {{16{i_stage.p_term[33]}}, i_stage.p_term}
               + {{1{i_stage.i_term[48]}}, i_stage.i_term}
               + {{16{i_stage.d_term[33]}}, i_stage.d_term};

    // dropping the low fraction bits floors toward minus infinity
    assign pwr = acc[49:FRAC_BITS];

    always_comb begin
        if (i_stage.restart || i_stage.settled) begin
            n_drive_power = 8'sd0;
        end else if (pwr > PWR_MAX) begin
            n_drive_power = PWR_MAX[7:0];
        end else if (pwr < PWR_MIN) begin
            n_drive_power = PWR_MIN[7:0];
        end else begin
            n_drive_power = pwr[7:0];
        end
        n_settled = i_stage.settled && !i_stage.restart;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_drive_power <= n_drive_power;
            r_settled     <= n_settled;
        end
    end

    assign o_drive_power = r_drive_power;
    assign o_settled     = r_settled;

endmodule

@@ hw/rtl/heading_turn_pid_controller.sv @@
// heading pid turn controller: four register stages (input, error, products, result)
// path: a command passes the input, error, product and result registers in turn
// throughput: one item per cycle unless the result channel stalls, bounded by the error sum update loop
// each stage advances when the one after it is empty or moving, so bubbles absorb stalls
// reset: synchronous active low; clears valids, error sum and last error, and loads config defaults
// depends on htpid_pkg, htpid_if, htpid_cfg, htpid_error, htpid_mult, htpid_sum
module heading_turn_pid_controller
    import htpid_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    htpid_cmd_if.sink             i_cmd,
    htpid_res_if.source           o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg        cfg;
    t_err_stage  err_stage;
    t_prod_stage prod_stage;

    logic               r_in_valid;
    logic               r_err_valid;
    logic               r_prod_valid;
    logic               r_out_valid;
    logic               r_in_op;
    logic signed [15:0] r_in_heading;

    logic en_in;
    logic en_err;
    logic en_prod;
    logic en_out;

    assign en_out  = !r_out_valid || o_res.ready;
    assign en_prod = !r_prod_valid || en_out;
    assign en_err  = !r_err_valid || en_prod;
    assign en_in   = !r_in_valid || en_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_err_valid  <= 1'b0;
            r_prod_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (en_in)   r_in_valid   <= i_cmd.valid;
            if (en_err)  r_err_valid  <= r_in_valid;
            if (en_prod) r_prod_valid <= r_err_valid;
            if (en_out)  r_out_valid  <= r_prod_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_in && i_cmd.valid) begin
            r_in_op      <= i_cmd.operation;
            r_in_heading <= i_cmd.measured_heading;
        end
    end

    htpid_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // integrator state moves only on a real transfer into the error stage
    htpid_error u_error (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (en_err && r_in_valid),
        .i_operation (r_in_op),
        .i_heading   (r_in_heading),
        .i_cfg       (cfg),
        .o_stage     (err_stage)
    );

    htpid_mult u_mult (
        .i_clk   (i_clk),
        .i_load  (en_prod && r_err_valid),
        .i_stage (err_stage),
        .i_cfg   (cfg),
        .o_stage (prod_stage)
    );

    htpid_sum u_sum (
        .i_clk         (i_clk),
        .i_load        (en_out && r_prod_valid),
        .i_stage       (prod_stage),
        .o_drive_power (o_res.drive_power),
        .o_settled     (o_res.settled)
    );

    assign i_cmd.ready = en_in;
    assign o_res.valid = r_out_valid;

endmodule

@@ hw/rtl/htpid_checker.sv @@
// port-level checker for the heading pid controller, bound to the top level
// depends on heading_turn_pid_controller_macros.svh
`include "heading_turn_pid_controller_macros.svh"

module htpid_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cmd_ready,
    input logic              i_res_valid,
    input logic              i_res_ready,
    input logic signed [7:0] i_res_drive_power,
    input logic              i_res_settled
);

    `HTPID_ASSERT_IMPL(a_settled_zero, i_clk, i_rst_n, i_res_valid && i_res_settled, i_res_drive_power == 8'sd0, "settled result carries nonzero power")

    `HTPID_ASSERT_IMPL(a_power_range, i_clk, i_rst_n, i_res_valid, i_res_drive_power != -8'sd128, "drive power outside clamp range")

    `HTPID_ASSERT_IMPL(a_empty_after_reset, i_clk, i_rst_n, $rose(i_rst_n), !i_res_valid && i_cmd_ready, "result valid or command blocked right after reset")

    `HTPID_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_drive_power) && $stable(i_res_settled), "stalled result changed")

endmodule

bind heading_turn_pid_controller htpid_checker u_htpid_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_cmd_ready       (i_cmd.ready),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_res_drive_power (o_res.drive_power),
    .i_res_settled     (o_res.settled)
);
